### sv/u8r_pkg.sv
// Shared types, codes and byte helpers for the UTF-8 reassembly block.
// Used by u8r_head, u8r_seq and utf8_reassembly_with_replacement_top.
`default_nettype none

package u8r_pkg;

    localparam int MAX_SEQUENCE_BYTES = 4;
    localparam int CNT_W = $clog2(MAX_SEQUENCE_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_SEQUENCE_BYTES);

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] REP_B0    = 8'hEF;
    localparam logic [7:0] REP_B1    = 8'hBF;
    localparam logic [7:0] REP_B2    = 8'hBD;

    typedef enum logic [1:0] {
        ACT_PUSH      = 2'd0,
        ACT_FLUSH     = 2'd1,
        ACT_FLUSH_REP = 2'd2,
        ACT_CLEAR     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT,
        S_REP,
        S_FIN
    } t_state;

    typedef struct packed {
        t_action    action;
        logic [7:0] data_byte;
    } t_u8r_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_u8r_out;

    // Verdict on the sequence at the head of the pending buffer.
    typedef struct packed {
        logic [CNT_W-1:0] need;
        logic             invalid;
        logic             incomplete;
        logic             cont_ok;
    } t_head;

    // Byte stream from the sequencer to the output stage.
    typedef struct packed {
        logic       emit;
        logic       fin;
        logic [7:0] data;
    } t_emit;

    function automatic logic [CNT_W-1:0] lead_length(input logic [7:0] b);
        logic [CNT_W-1:0] len;
        if (b inside {[8'h00:8'h7F]}) begin
            len = CNT_W'(1);
        end else if (b inside {[8'hC0:8'hDF]}) begin
            len = CNT_W'(2);
        end else if (b inside {[8'hE0:8'hEF]}) begin
            len = CNT_W'(3);
        end else if (b inside {[8'hF0:8'hF7]}) begin
            len = CNT_W'(4);
        end else begin
            len = '0;
        end
        return len;
    endfunction

    function automatic logic [7:0] rep_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: begin
                b = REP_B0;
            end
            2'd1: begin
                b = REP_B1;
            end
            default: begin
                b = REP_B2;
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### sv/utf8_reassembly_with_replacement_top.sv
// Top level of the UTF-8 reassembly block: output hold stage and result register.
// Depends on u8r_pkg and u8r_seq (which uses u8r_head).
//
// Usage:
// Requests arrive on the input channel (i_in_valid / o_in_ready) as an action and a
// data byte. A push appends the byte to a pending buffer of up to four bytes; a flush
// turns any incomplete tail into U+FFFD; flush-with-replacement adds one more U+FFFD;
// a clear drops the pending bytes silently. Each output request on o_out_valid /
// i_out_ready carries one UTF-8 byte, and last_byte marks the final byte that one
// input request produced. A request that produces nothing gives no output at all.
// The block takes one request at a time. A single sequencer drives one check unit
// over the pending buffer: it checks the head (a dropped byte leaves during its
// check), emits the bytes of a good sequence or of a U+FFFD one at a time, and then
// closes out the request. Output bytes pass through a one-byte hold stage so that
// last_byte is known before a byte is presented, then through the output register,
// so the first byte of a result appears only once the next byte or the close of the
// request moves it on. When the receiver stalls, the hold stage and output register
// fill and the sequencer simply waits; nothing is lost. Reset (synchronous, active
// low) empties the pending buffer and both output stages.
`default_nettype none

module utf8_reassembly_with_replacement_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire u8r_pkg::t_u8r_in i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output u8r_pkg::t_u8r_out     o_out
);
    import u8r_pkg::*;

    t_emit emit;
    logic  out_free;
    logic  step_ok;

    logic       r_hold_valid, n_hold_valid;
    logic [7:0] r_hold, n_hold;
    logic       r_out_valid, n_out_valid;
    t_u8r_out   r_out, n_out;

    // The sequencer decides what to emit; this level only buffers bytes.
    u8r_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .i_step_ok  (step_ok),
        .o_emit     (emit)
    );

    // The output register can take a new byte when it is empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;
    // The sequencer can advance when the hold stage is empty or can move on.
    assign step_ok  = !r_hold_valid || out_free;

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        if (emit.emit && step_ok) begin
            // A newer byte exists, so the held byte is not the last one.
            if (r_hold_valid) begin
                n_out_valid     = 1'b1;
                n_out.out_byte  = r_hold;
                n_out.last_byte = 1'b0;
            end
            n_hold_valid = 1'b1;
            n_hold       = emit.data;
        end else if (emit.fin && step_ok) begin
            // The request is done: whatever is held is its final byte.
            if (r_hold_valid) begin
                n_out_valid     = 1'b1;
                n_out.out_byte  = r_hold;
                n_out.last_byte = 1'b1;
            end
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_hold_valid)
        else $error("hold stage not empty while accepting a new request");

    a_fin_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.fin && step_ok && r_hold_valid) |=> (o_out_valid && o_out.last_byte))
        else $error("final byte of a request not marked last");

    a_emit_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.emit && step_ok && r_hold_valid) |=> (o_out_valid && !o_out.last_byte))
        else $error("byte with a successor marked last");

endmodule

`default_nettype wire

### sv/u8r_head.sv
// Check unit for the head of the pending buffer: lead length and continuation test.
// Depends on u8r_pkg.
`default_nettype none

module u8r_head (
    input  wire logic [u8r_pkg::MAX_SEQUENCE_BYTES-1:0][7:0] i_buf,
    input  wire logic [u8r_pkg::CNT_W-1:0]                   i_count,
    output u8r_pkg::t_head                                    o_head
);
    import u8r_pkg::*;

    logic [CNT_W-1:0] need;
    logic             cont_ok;

    always_comb begin
        need    = lead_length(i_buf[0]);
        cont_ok = 1'b1;
        for (int k = 1; k < MAX_SEQUENCE_BYTES; k++) begin
            if ((CNT_W'(k) < need) && ((i_buf[k] & CONT_MASK) != CONT_TAG)) begin
                cont_ok = 1'b0;
            end
        end
    end

    assign o_head.need       = need;
    assign o_head.invalid    = (need == '0);
    assign o_head.incomplete = (need > i_count);
    assign o_head.cont_ok    = cont_ok;

endmodule

`default_nettype wire

### sv/u8r_seq.sv
// Sequencer and pending buffer: walks the buffer one byte per step through the check unit.
// Depends on u8r_pkg and u8r_head.
`default_nettype none

module u8r_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire u8r_pkg::t_u8r_in i_in,
    output logic                  o_in_ready,
    input  wire logic             i_step_ok,
    output u8r_pkg::t_emit        o_emit
);
    import u8r_pkg::*;

    t_state r_state, n_state;
    logic [MAX_SEQUENCE_BYTES-1:0][7:0] r_buf, n_buf;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic [1:0]       r_rep_idx, n_rep_idx;
    logic             r_force, n_force;
    logic             r_tail_rep, n_tail_rep;

    t_head head;
    logic  accept;
    logic  drop_one;

    u8r_head u_head (
        .i_buf   (r_buf),
        .i_count (r_count),
        .o_head  (head)
    );

    assign accept = i_in_valid && (r_state == S_IDLE);

    // A head that can never become a good sequence loses one byte.
    assign drop_one = head.invalid || (head.incomplete && r_force)
                   || (!head.incomplete && !head.cont_ok);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.action != ACT_CLEAR)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_count == '0) begin
                    n_state = r_tail_rep ? S_REP : S_FIN;
                end else if (drop_one) begin
                    n_state = S_REP;
                end else if (head.incomplete) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_step_ok && (r_left == CNT_W'(1))) begin
                    n_state = S_CHECK;
                end
            end
            S_REP: begin
                if (i_step_ok && (r_rep_idx == 2'd2)) begin
                    n_state = S_CHECK;
                end
            end
            S_FIN: begin
                if (i_step_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_buf      = r_buf;
        n_count    = r_count;
        n_left     = r_left;
        n_rep_idx  = r_rep_idx;
        n_force    = r_force;
        n_tail_rep = r_tail_rep;
        o_emit     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_force    = (i_in.action != ACT_PUSH);
                    n_tail_rep = (i_in.action == ACT_FLUSH_REP);
                    case (i_in.action)
                        ACT_PUSH: begin
                            if (r_count < CNT_W'(MAX_SEQUENCE_BYTES)) begin
                                n_buf[r_count[IDX_W-1:0]] = i_in.data_byte;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_rep_idx = '0;
                if (r_count == '0) begin
                    n_tail_rep = 1'b0;
                end else if (drop_one) begin
                    for (int i = 0; i < MAX_SEQUENCE_BYTES - 1; i++) begin
                        n_buf[i] = r_buf[i+1];
                    end
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_left = head.need;
                end
            end
            S_EMIT: begin
                o_emit.emit = 1'b1;
                o_emit.data = r_buf[0];
                if (i_step_ok) begin
                    for (int i = 0; i < MAX_SEQUENCE_BYTES - 1; i++) begin
                        n_buf[i] = r_buf[i+1];
                    end
                    n_count = r_count - CNT_W'(1);
                    n_left  = r_left - CNT_W'(1);
                end
            end
            S_REP: begin
                o_emit.emit = 1'b1;
                o_emit.data = rep_byte(r_rep_idx);
                if (i_step_ok) begin
                    n_rep_idx = r_rep_idx + 2'd1;
                end
            end
            S_FIN: begin
                o_emit.fin = 1'b1;
            end
            default: begin
                o_emit = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_buf      <= '0;
            r_count    <= '0;
            r_left     <= '0;
            r_rep_idx  <= '0;
            r_force    <= 1'b0;
            r_tail_rep <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_buf      <= n_buf;
            r_count    <= n_count;
            r_left     <= n_left;
            r_rep_idx  <= n_rep_idx;
            r_force    <= n_force;
            r_tail_rep <= n_tail_rep;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < CNT_W'(MAX_SEQUENCE_BYTES)))
        else $error("pending buffer holds a whole sequence while idle");

    a_emit_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((r_left != '0) && (r_count >= r_left)))
        else $error("emitting more bytes than are pending");

    a_rep_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REP) |-> (r_rep_idx <= 2'd2))
        else $error("replacement byte index out of range");

endmodule

`default_nettype wire
